// ===== rtl/core/cesc_pkg.sv =====
// ----------------------------------------------------------------------------
// cesc_pkg: shared types and helpers for the C string escape codec
// Byte codes, configuration register indexes and the front-to-back queue word.
// ----------------------------------------------------------------------------
package cesc_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int LIMIT_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BELL      = 8'h07;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_FORMFEED  = 8'h0C;
  localparam logic [7:0] CH_LET_T     = 8'h74;
  localparam logic [7:0] CH_LET_N     = 8'h6E;
  localparam logic [7:0] CH_LET_R     = 8'h72;
  localparam logic [7:0] CH_LET_A     = 8'h61;
  localparam logic [7:0] CH_LET_B     = 8'h62;
  localparam logic [7:0] CH_LET_F     = 8'h66;

  // One result word as the back end sends it.
  typedef struct packed {
    logic [7:0] data;
    logic       is_len;
  } slot_t;

  // Work for the back end caused by one input word: one or two results.
  typedef struct packed {
    logic [1:0]             cnt;
    slot_t [1:0]            slots;
    logic [LENGTH_BITS-1:0] total;
  } entry_t;

  // Letter after the backslash when escaping, NUL for a plain byte.
  function automatic logic [7:0] escape_letter(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      CH_BACKSLASH: r = CH_BACKSLASH;
      CH_QUOTE:     r = CH_QUOTE;
      CH_TAB:       r = CH_LET_T;
      CH_NEWLINE:   r = CH_LET_N;
      CH_CR:        r = CH_LET_R;
      CH_BELL:      r = CH_LET_A;
      CH_BACKSPACE: r = CH_LET_B;
      CH_FORMFEED:  r = CH_LET_F;
      default:      r = CH_NUL;
    endcase
    return r;
  endfunction

  // Byte decoded from a backslash sequence, NUL when the sequence is unknown.
  function automatic logic [7:0] unescape_byte(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      CH_QUOTE:     r = CH_QUOTE;
      CH_BACKSLASH: r = CH_BACKSLASH;
      CH_LET_T:     r = CH_TAB;
      CH_LET_N:     r = CH_NEWLINE;
      CH_LET_R:     r = CH_CR;
      CH_LET_A:     r = CH_BELL;
      CH_LET_B:     r = CH_BACKSPACE;
      CH_LET_F:     r = CH_FORMFEED;
      default:      r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/c_string_escape_codec_top.sv =====
// Path: an accepted word is written into the queue, then loaded into the output
//   register, where its first result waits for the consumer.
// Throughput: one input word per cycle while out_ready holds and each word yields
//   at most one result; two results of a word share the single output register.
// Reset: synchronous, active low; direction returns to escape, length_limit to 256,
//   counters, queue and output register clear.
// ----------------------------------------------------------------------------
// c_string_escape_codec_top: C string backslash escape/unescape codec
// Front classifies each byte and updates string state, a two-entry queue holds
// the pending results, and the back end sequences them onto the output channel.
// ----------------------------------------------------------------------------
module c_string_escape_codec_top import cesc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // source byte channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_out_byte,
  output logic                   out_is_length,
  output logic [LENGTH_BITS-1:0] out_total_length,
  output logic                   out_last
);

  // Front to queue: hold the result pair built for each accepted word.
  logic   push;
  entry_t push_ent;
  // Queue to back: advance one entry once its last result is loaded.
  logic   q_full;
  logic   q_empty;
  logic   pop;
  entry_t head;

  cesc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_ent     (push_ent)
  );

  // Words that produce nothing (halted bytes, a held backslash) skip the queue.
  cesc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  // Output register parts the queue from the consumer, so a stall on the
  // result side only backs up once both queue entries are taken.
  cesc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_byte     (out_out_byte),
    .out_is_length    (out_is_length),
    .out_total_length (out_total_length),
    .out_last         (out_last)
  );

`ifndef ASSERT_OFF
  a_push_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_ent.cnt == 2'd1 || push_ent.cnt == 2'd2))
    else $error("queue word pushed with no results");

  a_len_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_length) |-> (out_last && out_out_byte == CH_NUL))
    else $error("length result not final or carries a byte");

  a_byte_no_total : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_length) |-> (out_total_length == '0))
    else $error("byte result carries a total length");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue popped while empty");
`endif

endmodule

// ===== rtl/core/cesc_front.sv =====
// ----------------------------------------------------------------------------
// cesc_front: word classifier and string state
// Holds configuration and per-string counters, turns each word into queue work.
// ----------------------------------------------------------------------------
module cesc_front import cesc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  q_full,
  output logic                  push,
  output entry_t                push_ent
);

  logic                   direction_r;
  logic [LIMIT_W-1:0]     length_limit_r;
  logic                   pending_r, pending_nxt;
  logic                   halted_r, halted_nxt;
  logic [LENGTH_BITS-1:0] produced_r, produced_nxt;
  logic [LENGTH_BITS-1:0] consumed_r, consumed_nxt;
  logic [LENGTH_BITS-1:0] cap;
  logic                   accept;
  entry_t                 ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cap      = (length_limit_r < COUNT_MAX) ? length_limit_r : COUNT_MAX;

  always_comb begin
    logic [7:0] c;
    logic [7:0] letter;
    logic [7:0] dec;
    logic       done;
    c            = in_data_byte;
    letter       = escape_letter(c);
    dec          = (c != CH_NUL) ? unescape_byte(c) : CH_NUL;
    done         = 1'b0;
    ent          = '0;
    pending_nxt  = pending_r;
    halted_nxt   = halted_r;
    produced_nxt = produced_r;
    consumed_nxt = consumed_r;
    if (!direction_r) begin
      pending_nxt = 1'b0;
      if (c == CH_NUL) begin
        ent.slots[0] = '{data: CH_NUL, is_len: 1'b1};
        ent.cnt      = 2'd1;
        ent.total    = produced_r;
        produced_nxt = '0;
        consumed_nxt = '0;
        halted_nxt   = 1'b0;
      end else if (!halted_r) begin
        if (letter != CH_NUL) begin
          if ({1'b0, produced_r} + 1'b1 < {1'b0, cap}) begin
            ent.slots[0] = '{data: CH_BACKSLASH, is_len: 1'b0};
            ent.slots[1] = '{data: letter, is_len: 1'b0};
            ent.cnt      = 2'd2;
            produced_nxt = produced_r + LENGTH_BITS'(2);
          end else begin
            halted_nxt = 1'b1;
          end
        end else if (produced_r < cap) begin
          ent.slots[0] = '{data: c, is_len: 1'b0};
          ent.cnt      = 2'd1;
          produced_nxt = produced_r + 1'b1;
        end else begin
          halted_nxt = 1'b1;
        end
      end
    end else begin
      if (pending_r) begin
        pending_nxt = 1'b0;
        if (dec != CH_NUL) begin
          ent.slots[0] = '{data: dec, is_len: 1'b0};
          produced_nxt = produced_nxt + 1'b1;
          if (consumed_nxt < COUNT_MAX) begin
            consumed_nxt = consumed_nxt + 1'b1;
          end
          done = 1'b1;
        end else begin
          ent.slots[0] = '{data: CH_BACKSLASH, is_len: 1'b0};
          produced_nxt = produced_nxt + 1'b1;
        end
        ent.cnt = 2'd1;
      end
      if (!done) begin
        if (c == CH_NUL) begin
          ent.slots[ent.cnt[0]] = '{data: CH_NUL, is_len: 1'b1};
          ent.total    = produced_nxt;
          ent.cnt      = ent.cnt + 2'd1;
          produced_nxt = '0;
          consumed_nxt = '0;
          halted_nxt   = 1'b0;
          pending_nxt  = 1'b0;
        end else if (!halted_r) begin
          if (consumed_nxt < cap) begin
            consumed_nxt = consumed_nxt + 1'b1;
            if (c == CH_BACKSLASH) begin
              pending_nxt = 1'b1;
            end else begin
              ent.slots[ent.cnt[0]] = '{data: c, is_len: 1'b0};
              ent.cnt      = ent.cnt + 2'd1;
              produced_nxt = produced_nxt + 1'b1;
            end
          end else begin
            halted_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign push     = accept && (ent.cnt != 2'd0);
  assign push_ent = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r    <= 1'b0;
      length_limit_r <= LIMIT_RESET;
      pending_r      <= 1'b0;
      halted_r       <= 1'b0;
      produced_r     <= '0;
      consumed_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DIRECTION:    direction_r    <= cfg_data[0];
          REG_LENGTH_LIMIT: length_limit_r <= cfg_data[LIMIT_W-1:0];
          default:          ;
        endcase
      end
      if (accept) begin
        pending_r  <= pending_nxt;
        halted_r   <= halted_nxt;
        produced_r <= produced_nxt;
        consumed_r <= consumed_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/cesc_queue.sv =====
// ----------------------------------------------------------------------------
// cesc_queue: two-entry work queue
// Decouples the classifier from the output sequencer.
// ----------------------------------------------------------------------------
module cesc_queue import cesc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_ent,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t     ent_r [QUEUE_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'(QUEUE_DEPTH));
  assign empty = (count_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/cesc_back.sv =====
// ----------------------------------------------------------------------------
// cesc_back: output sequencer
// Sends the one or two results of each queue entry through the output register.
// ----------------------------------------------------------------------------
module cesc_back import cesc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  entry_t                 head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_out_byte,
  output logic                   out_is_length,
  output logic [LENGTH_BITS-1:0] out_total_length,
  output logic                   out_last
);

  logic                   sub_r;
  logic                   valid_r;
  logic [7:0]             byte_r;
  logic                   is_len_r;
  logic [LENGTH_BITS-1:0] total_r;
  logic                   last_r;
  logic                   load;
  logic                   at_last;
  slot_t                  cur;

  assign load    = !q_empty && (!valid_r || out_ready);
  assign at_last = sub_r || (head.cnt == 2'd1);
  assign pop     = load && at_last;
  assign cur     = head.slots[sub_r];

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= cur.data;
      is_len_r <= cur.is_len;
      total_r  <= cur.is_len ? head.total : '0;
      last_r   <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sub_r   <= !at_last;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_out_byte     = byte_r;
  assign out_is_length    = is_len_r;
  assign out_total_length = total_r;
  assign out_last         = last_r;

endmodule

// ===== tb/cesc_result_checker.sv =====
// ----------------------------------------------------------------------------
// cesc_result_checker: result predictor and scoreboard for the escape codec
// Watches the configuration port and both channels, predicts the result words
// of every accepted source byte and compares them with what the block sends.
// ----------------------------------------------------------------------------
module cesc_result_checker import cesc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [7:0]             out_out_byte,
  input  logic                   out_is_length,
  input  logic [LENGTH_BITS-1:0] out_total_length,
  input  logic                   out_last,
  output int                     fail_count,
  output int                     expected_left
);

  typedef struct packed {
    logic [7:0]             data;
    logic                   is_len;
    logic [LENGTH_BITS-1:0] total;
    logic                   last;
  } codec_result_t;

  // Raw byte and the letter that stands for it after a backslash.
  localparam logic [7:0] RAW_CH [8] = '{CH_BACKSLASH, CH_QUOTE, CH_TAB, CH_NEWLINE,
                                        CH_CR, CH_BELL, CH_BACKSPACE, CH_FORMFEED};
  localparam logic [7:0] LETTER_CH [8] = '{CH_BACKSLASH, CH_QUOTE, CH_LET_T, CH_LET_N,
                                           CH_LET_R, CH_LET_A, CH_LET_B, CH_LET_F};

  codec_result_t       awaited_q[$];
  codec_result_t       step_q[$];
  logic                unescape_mode;
  logic [LIMIT_W-1:0]  limit_reg;
  bit                  bs_held;
  bit                  stopped;
  int                  produced_n;
  int                  consumed_n;

  function automatic logic [7:0] escape_code(input logic [7:0] c);
    logic [7:0] code;
    code = CH_NUL;
    for (int i = 0; i < 8; i++) begin
      if (RAW_CH[i] == c) code = LETTER_CH[i];
    end
    return code;
  endfunction

  function automatic logic [7:0] decode_code(input logic [7:0] c);
    logic [7:0] raw;
    raw = CH_NUL;
    for (int i = 0; i < 8; i++) begin
      if (LETTER_CH[i] == c) raw = RAW_CH[i];
    end
    return raw;
  endfunction

  task automatic push_byte(input logic [7:0] d);
    codec_result_t r;
    r = '0;
    r.data = d;
    step_q.push_back(r);
    produced_n = produced_n + 1;
  endtask

  // Length word closes the string and clears all string state.
  task automatic end_string();
    codec_result_t r;
    r = '0;
    r.is_len = 1'b1;
    r.total  = produced_n[LENGTH_BITS-1:0];
    step_q.push_back(r);
    produced_n = 0;
    consumed_n = 0;
    stopped    = 0;
    bs_held    = 0;
  endtask

  task automatic predict_word(input logic [7:0] c);
    logic [7:0]    code;
    codec_result_t tail;
    int            cap;
    bit            taken;
    cap   = int'(limit_reg);
    taken = 0;
    step_q.delete();
    if (!unescape_mode) begin
      bs_held = 0;
      if (c == CH_NUL) begin
        end_string();
      end else if (!stopped) begin
        code = escape_code(c);
        if (code != CH_NUL) begin
          if (produced_n + 1 < cap) begin
            push_byte(CH_BACKSLASH);
            push_byte(code);
          end else begin
            stopped = 1;
          end
        end else if (produced_n < cap) begin
          push_byte(c);
        end else begin
          stopped = 1;
        end
      end
    end else begin
      if (bs_held) begin
        code    = (c != CH_NUL) ? decode_code(c) : CH_NUL;
        bs_held = 0;
        if (code != CH_NUL) begin
          // second byte of a known sequence is taken even past the limit
          push_byte(code);
          if (consumed_n < int'(COUNT_MAX)) consumed_n = consumed_n + 1;
          taken = 1;
        end else begin
          push_byte(CH_BACKSLASH);
        end
      end
      if (!taken) begin
        if (c == CH_NUL) begin
          end_string();
        end else if (!stopped) begin
          if (consumed_n < cap) begin
            consumed_n = consumed_n + 1;
            if (c == CH_BACKSLASH) bs_held = 1;
            else push_byte(c);
          end else begin
            stopped = 1;
          end
        end
      end
    end
    if (step_q.size() != 0) begin
      tail = step_q.pop_back();
      tail.last = 1'b1;
      step_q.push_back(tail);
    end
    while (step_q.size() != 0) awaited_q.push_back(step_q.pop_front());
  endtask

  task automatic check_result();
    codec_result_t want;
    if (awaited_q.size() == 0) begin
      fail_count++;
      $display("%0t: result with nothing expected: byte %02h length flag %0b total %0d",
               $time, out_out_byte, out_is_length, out_total_length);
    end else begin
      want = awaited_q.pop_front();
      if (out_out_byte !== want.data) begin
        fail_count++;
        $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_out_byte);
      end
      if (out_is_length !== want.is_len) begin
        fail_count++;
        $display("%0t: is_length expected %0b got %0b", $time, want.is_len, out_is_length);
      end
      if (out_total_length !== want.total) begin
        fail_count++;
        $display("%0t: total_length expected %0d got %0d", $time, want.total,
                 out_total_length);
      end
      if (out_last !== want.last) begin
        fail_count++;
        $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      unescape_mode = 1'b0;
      limit_reg     = LIMIT_RESET;
      bs_held       = 0;
      stopped       = 0;
      produced_n    = 0;
      consumed_n    = 0;
      fail_count    = 0;
      awaited_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_DIRECTION) unescape_mode = cfg_data[0];
        else if (cfg_index == REG_LENGTH_LIMIT) limit_reg = cfg_data[LIMIT_W-1:0];
      end
      if (in_valid && in_ready) predict_word(in_data_byte);
      if (out_valid && out_ready) check_result();
    end
    expected_left = awaited_q.size();
  end

endmodule

// ===== tb/c_string_escape_codec_top_tb.sv =====
// ----------------------------------------------------------------------------
// c_string_escape_codec_top_tb: stimulus and verdict for the escape codec
// Drives directed strings through every escape, limit and mode corner, then
// random escape and unescape strings under several register settings with
// random stalls on both channels; a separate checker scores every result word.
// ----------------------------------------------------------------------------
module c_string_escape_codec_top_tb;
  import cesc_pkg::*;

  localparam int   CYCLE_LIMIT     = 300000;
  localparam int   HOLD_CYCLES     = 64;
  localparam int   ITEMS_PER_PHASE = 75;
  localparam int   DRAIN_CYCLES    = 6;
  localparam logic DIR_ESCAPE      = 1'b0;
  localparam logic DIR_UNESCAPE    = 1'b1;

  // Extra pressure applied to one phase.
  typedef enum int {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} press_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_data_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             out_out_byte;
  logic                   out_is_length;
  logic [LENGTH_BITS-1:0] out_total_length;
  logic                   out_last;

  int fail_count;
  int expected_left;
  int words_sent;
  int hold_requests;
  int holds_served;
  bit quiet;

  c_string_escape_codec_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_byte     (out_out_byte),
    .out_is_length    (out_is_length),
    .out_total_length (out_total_length),
    .out_last         (out_last)
  );

  cesc_result_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_byte     (out_out_byte),
    .out_is_length    (out_is_length),
    .out_total_length (out_total_length),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .expected_left    (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: a stuck handshake or a lost result ends here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: stall in random bursts, serve long hold requests from the
  // stimulus in cycles counted here, and stay ready during the quiet tail.
  initial begin
    out_ready    = 1'b0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        out_ready <= 1'b0;
        holds_served = holds_served + 1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one word and return at the edge that accepts it. Ready is sampled
  // at the falling edge, where nothing driven at the rising edge is in flight.
  task automatic send_word(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait until every predicted word is back, then let a few
  // more cycles pass for words that cause no result but may still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_left != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic dir, input logic [LIMIT_W-1:0] limit);
    drain();
    write_reg(REG_DIRECTION, CFG_DATA_W'(dir));
    write_reg(REG_LENGTH_LIMIT, limit);
  endtask

  function automatic logic [7:0] pick_special();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = CH_BACKSLASH;
      1: c = CH_QUOTE;
      2: c = CH_TAB;
      3: c = CH_NEWLINE;
      4: c = CH_CR;
      5: c = CH_BELL;
      6: c = CH_BACKSPACE;
      default: c = CH_FORMFEED;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = CH_BACKSLASH;
      1: c = CH_QUOTE;
      2: c = CH_LET_T;
      3: c = CH_LET_N;
      4: c = CH_LET_R;
      5: c = CH_LET_A;
      6: c = CH_LET_B;
      default: c = CH_LET_F;
    endcase
    return c;
  endfunction

  // Raw string: specials, printable text and any nonzero byte, then NUL.
  task automatic send_raw_string(input int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3) send_word(pick_special());
      else if (r < 5) send_word(8'($urandom_range(32, 126)));
      else send_word(8'($urandom_range(1, 255)));
    end
    send_word(CH_NUL);
  endtask

  // Escaped string: mostly known sequences, some unknown ones and plain bytes,
  // sometimes a dangling backslash right before the NUL.
  task automatic send_coded_string(input int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        send_word(CH_BACKSLASH);
        send_word(pick_letter());
      end else if (r < 5) begin
        send_word(CH_BACKSLASH);
        send_word(8'($urandom_range(1, 255)));
      end else begin
        send_word(8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(0, 7) == 0) send_word(CH_BACKSLASH);
    send_word(CH_NUL);
  endtask

  task automatic run_phase(input logic dir, input logic [LIMIT_W-1:0] limit,
                           input press_t press);
    int start;
    int len;
    bit paused;
    set_mode(dir, limit);
    start  = words_sent;
    paused = 0;
    // Hold the result side off while words keep coming, so the queue fills.
    if (press == PRESS_HOLD) hold_requests <= hold_requests + 1;
    while (words_sent - start < ITEMS_PER_PHASE) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (dir == DIR_UNESCAPE && $urandom_range(0, 4) != 0) send_coded_string(len);
      else send_raw_string(len);
      // Pause the sender once until every result is home.
      if (press == PRESS_PAUSE && !paused) begin
        drain();
        paused = 1;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_DIRECTION;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_data_byte  = CH_NUL;
    words_sent    = 0;
    hold_requests = 0;
    quiet         = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Escape at reset settings: every special byte, byte extremes.
    send_word(CH_BACKSLASH);
    send_word(CH_QUOTE);
    send_word(CH_TAB);
    send_word(CH_NEWLINE);
    send_word(CH_CR);
    send_word(CH_BELL);
    send_word(CH_BACKSPACE);
    send_word(CH_FORMFEED);
    send_word(8'h01);
    send_word(8'hFF);
    send_word(CH_NUL);

    // Escape limit: a pair that just fits, then one that does not; halt to NUL.
    set_mode(DIR_ESCAPE, 16'd3);
    send_word(8'h78);
    send_word(CH_TAB);
    send_word(CH_QUOTE);
    send_word(8'h79);
    send_word(CH_NUL);

    // Unescape: known sequence, unknown sequence, backslash pending at the end.
    set_mode(DIR_UNESCAPE, LIMIT_RESET);
    send_word(CH_BACKSLASH);
    send_word(CH_LET_N);
    send_word(CH_BACKSLASH);
    send_word(8'h71);
    send_word(CH_QUOTE);
    send_word(CH_BACKSLASH);
    send_word(CH_NUL);

    // Unescape limit: second byte of a sequence is taken past it, then halt.
    set_mode(DIR_UNESCAPE, 16'd2);
    send_word(8'h61);
    send_word(CH_BACKSLASH);
    send_word(CH_LET_T);
    send_word(8'h63);
    send_word(CH_NUL);

    // Zero limit: only a zero length comes out.
    set_mode(DIR_ESCAPE, 16'd0);
    send_word(8'h61);
    send_word(CH_NUL);

    // Mode switch mid-string: counters carry over, escape drops the backslash.
    set_mode(DIR_UNESCAPE, LIMIT_RESET);
    send_word(8'h61);
    send_word(CH_BACKSLASH);
    drain();
    write_reg(REG_DIRECTION, CFG_DATA_W'(DIR_ESCAPE));
    send_word(8'h62);
    send_word(CH_NUL);

    // Random strings across the settings, extremes included.
    run_phase(DIR_ESCAPE,   LIMIT_RESET, PRESS_HOLD);
    run_phase(DIR_UNESCAPE, LIMIT_RESET, PRESS_NONE);
    run_phase(DIR_ESCAPE,   16'd1,       PRESS_NONE);
    run_phase(DIR_UNESCAPE, 16'd1,       PRESS_NONE);
    run_phase(DIR_ESCAPE,   16'hFFFF,    PRESS_PAUSE);
    run_phase(DIR_UNESCAPE, 16'hFFFF,    PRESS_HOLD);
    run_phase(DIR_ESCAPE,   16'($urandom_range(2, 24)), PRESS_NONE);
    run_phase(DIR_UNESCAPE, 16'($urandom_range(2, 24)), PRESS_PAUSE);
    run_phase(DIR_ESCAPE,   16'($urandom_range(2, 24)), PRESS_NONE);
    // Last phase at full rate on both sides.
    drain();
    quiet <= 1'b1;
    run_phase(DIR_UNESCAPE, 16'($urandom_range(2, 24)), PRESS_NONE);
    drain();

    if (fail_count == 0 && expected_left == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
